@@ rtl/mcfe_pkg.sv @@
// Shared constants and types for the motor command frame encoder.
package mcfe_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned QuotW   = 16;
  localparam int unsigned NumW    = ValueW + QuotW;
  localparam int unsigned CfgIdxW = 4;

  // Code widths of the five fields
  localparam int unsigned PosBits = 16;
  localparam int unsigned VelBits = 12;
  localparam int unsigned TrqBits = 12;
  localparam int unsigned KpBits  = 12;
  localparam int unsigned KdBits  = 9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POS_LO = 4'd0,
    CFG_POS_HI = 4'd1,
    CFG_VEL_LO = 4'd2,
    CFG_VEL_HI = 4'd3,
    CFG_TRQ_LO = 4'd4,
    CFG_TRQ_HI = 4'd5,
    CFG_KP_HI  = 4'd6,
    CFG_KD_HI  = 4'd7
  } cfg_idx_t;

  localparam logic signed [ValueW-1:0] PosLoRst = -32'sd819200;
  localparam logic signed [ValueW-1:0] PosHiRst = 32'sd819200;
  localparam logic signed [ValueW-1:0] VelLoRst = -32'sd2949120;
  localparam logic signed [ValueW-1:0] VelHiRst = 32'sd2949120;
  localparam logic signed [ValueW-1:0] TrqLoRst = -32'sd1179648;
  localparam logic signed [ValueW-1:0] TrqHiRst = 32'sd1179648;
  localparam logic signed [ValueW-1:0] KpHiRst  = 32'sd32768000;
  localparam logic signed [ValueW-1:0] KdHiRst  = 32'sd327680;

endpackage

@@ rtl/mcfe_div_lane.sv @@
// Pipelined restoring divider lane: one quotient bit per register stage.
module mcfe_div_lane (
  input  logic                             clk,
  input  logic                             adv,
  input  logic [mcfe_pkg::NumW-1:0]        num,
  input  logic [mcfe_pkg::ValueW-1:0]      span,
  output logic [mcfe_pkg::QuotW-1:0]       quot
);

  localparam int unsigned VW = mcfe_pkg::ValueW;
  localparam int unsigned QW = mcfe_pkg::QuotW;

  // Stage 0 holds the loaded operands, stage k holds k quotient bits
  logic [VW-1:0] rem_r  [0:QW];
  logic [QW-1:0] low_r  [0:QW];
  logic [QW-1:0] q_r    [0:QW];
  logic [VW-1:0] span_r [0:QW];

  // Load: numerator top bits are below span since quotient fits QW bits
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= num[mcfe_pkg::NumW-1:QW];
      low_r[0]  <= num[QW-1:0];
      q_r[0]    <= '0;
      span_r[0] <= span;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          take;
    always_comb begin
      trial = {rem_r[k], low_r[k][QW-1]};
      diff  = trial - {1'b0, span_r[k]};
      take  = (trial >= {1'b0, span_r[k]});
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]  <= take ? diff[VW-1:0] : trial[VW-1:0];
        low_r[k+1]  <= {low_r[k][QW-2:0], 1'b0};
        q_r[k+1]    <= {q_r[k][QW-2:0], take};
        span_r[k+1] <= span_r[k];
      end
    end
  end

  assign quot = q_r[QW];

endmodule

@@ rtl/motor_command_frame_encoder.sv @@
// Top level of the motor command frame encoder.
// Usage:
//   A command request (position, velocity, torque, stiffness and damping
//   gain, signed Q16.16) enters on in_valid / in_stall. Each frame leaves on
//   out_valid / out_stall as eight bytes plus range_error.
//   Each value is checked against its limits and scaled to its code by a
//   pipelined divider that yields one quotient bit per stage.
//   Pipeline: 1 check stage, 17 divider stages and 1 output register lie
//   between acceptance and out_valid. Throughput: one command per cycle,
//   set by the divider pipeline, while no held frame stalls the output.
//   When out_stall holds a valid frame, the whole pipeline freezes and
//   in_stall rises; nothing is lost or repeated.
//   The user must write limits through cfg_we / cfg_index / cfg_wdata
//   only while idle (the block does not enforce it); writes to an index
//   above 7 are ignored. Reset (rst_n low, synchronous) empties the
//   pipeline and restores the default limits.
//   A bad limit pair or out-of-range value gives range_error = 1 and zero
//   bytes.
module motor_command_frame_encoder #(
  parameter logic signed [31:0] STIFFNESS_LOW = 32'sd0,
  parameter logic signed [31:0] DAMPING_LOW   = 32'sd0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mcfe_pkg::ValueW-1:0]  in_target_position,
  input  logic signed [mcfe_pkg::ValueW-1:0]  in_target_velocity,
  input  logic signed [mcfe_pkg::ValueW-1:0]  in_target_torque,
  input  logic signed [mcfe_pkg::ValueW-1:0]  in_stiffness_gain,
  input  logic signed [mcfe_pkg::ValueW-1:0]  in_damping_gain,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_frame_byte0,
  output logic [7:0]                          out_frame_byte1,
  output logic [7:0]                          out_frame_byte2,
  output logic [7:0]                          out_frame_byte3,
  output logic [7:0]                          out_frame_byte4,
  output logic [7:0]                          out_frame_byte5,
  output logic [7:0]                          out_frame_byte6,
  output logic [7:0]                          out_frame_byte7,
  output logic                                out_range_error,
  input  logic                                cfg_we,
  input  logic [mcfe_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [mcfe_pkg::ValueW-1:0]         cfg_wdata
);

  localparam int unsigned VW   = mcfe_pkg::ValueW;
  localparam int unsigned QW   = mcfe_pkg::QuotW;
  localparam int unsigned NW   = mcfe_pkg::NumW;
  localparam int unsigned NL   = 5;
  localparam int unsigned LatD = QW + 1;

  // Limit registers
  logic signed [VW-1:0] pos_lo_r, pos_hi_r, vel_lo_r, vel_hi_r;
  logic signed [VW-1:0] trq_lo_r, trq_hi_r, kp_hi_r, kd_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_lo_r <= mcfe_pkg::PosLoRst;
      pos_hi_r <= mcfe_pkg::PosHiRst;
      vel_lo_r <= mcfe_pkg::VelLoRst;
      vel_hi_r <= mcfe_pkg::VelHiRst;
      trq_lo_r <= mcfe_pkg::TrqLoRst;
      trq_hi_r <= mcfe_pkg::TrqHiRst;
      kp_hi_r  <= mcfe_pkg::KpHiRst;
      kd_hi_r  <= mcfe_pkg::KdHiRst;
    end else if (cfg_we) begin
      case (mcfe_pkg::cfg_idx_t'(cfg_index))
        mcfe_pkg::CFG_POS_LO: pos_lo_r <= cfg_wdata;
        mcfe_pkg::CFG_POS_HI: pos_hi_r <= cfg_wdata;
        mcfe_pkg::CFG_VEL_LO: vel_lo_r <= cfg_wdata;
        mcfe_pkg::CFG_VEL_HI: vel_hi_r <= cfg_wdata;
        mcfe_pkg::CFG_TRQ_LO: trq_lo_r <= cfg_wdata;
        mcfe_pkg::CFG_TRQ_HI: trq_hi_r <= cfg_wdata;
        mcfe_pkg::CFG_KP_HI:  kp_hi_r  <= cfg_wdata;
        mcfe_pkg::CFG_KD_HI:  kd_hi_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a finished frame is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Check stage: limits, offsets and spans
  logic signed [VW-1:0] val   [NL];
  logic signed [VW-1:0] lo    [NL];
  logic signed [VW-1:0] hi    [NL];
  logic [VW-1:0]        off_c [NL];
  logic [VW-1:0]        spn_c [NL];
  logic                 bad_c;

  always_comb begin
    val[0] = in_target_position; lo[0] = pos_lo_r;      hi[0] = pos_hi_r;
    val[1] = in_target_velocity; lo[1] = vel_lo_r;      hi[1] = vel_hi_r;
    val[2] = in_target_torque;   lo[2] = trq_lo_r;      hi[2] = trq_hi_r;
    val[3] = in_stiffness_gain;  lo[3] = STIFFNESS_LOW; hi[3] = kp_hi_r;
    val[4] = in_damping_gain;    lo[4] = DAMPING_LOW;   hi[4] = kd_hi_r;
    bad_c = 1'b0;
    for (int i = 0; i < NL; i++) begin
      off_c[i] = val[i] - lo[i];
      spn_c[i] = hi[i] - lo[i];
      if (!(lo[i] < hi[i]) || (val[i] < lo[i]) || (val[i] > hi[i])) begin
        bad_c = 1'b1;
      end
    end
  end

  logic [VW-1:0] off_r [NL];
  logic [VW-1:0] spn_r [NL];
  logic          vld_r [0:LatD];
  logic          err_r [0:LatD];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        off_r[i] <= off_c[i];
        spn_r[i] <= spn_c[i];
      end
      err_r[0] <= bad_c;
      for (int k = 0; k < LatD; k++) begin
        err_r[k+1] <= err_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LatD; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 0; k < LatD; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  // Numerators off * (2^n - 1), then one divider lane per field
  logic [NW-1:0] num [NL];
  logic [QW-1:0] quo [NL];

  always_comb begin
    num[0] = ({{QW{1'b0}}, off_r[0]} << mcfe_pkg::PosBits) - {{QW{1'b0}}, off_r[0]};
    num[1] = ({{QW{1'b0}}, off_r[1]} << mcfe_pkg::VelBits) - {{QW{1'b0}}, off_r[1]};
    num[2] = ({{QW{1'b0}}, off_r[2]} << mcfe_pkg::TrqBits) - {{QW{1'b0}}, off_r[2]};
    num[3] = ({{QW{1'b0}}, off_r[3]} << mcfe_pkg::KpBits) - {{QW{1'b0}}, off_r[3]};
    num[4] = ({{QW{1'b0}}, off_r[4]} << mcfe_pkg::KdBits) - {{QW{1'b0}}, off_r[4]};
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    mcfe_div_lane u_div (
      .clk  (clk),
      .adv  (adv),
      .num  (num[l]),
      .span (spn_r[l]),
      .quot (quo[l])
    );
  end

  // Output register: pack codes, zero on error
  logic [15:0] cp;
  logic [11:0] cv, ct, ckp;
  logic [8:0]  ckd;
  logic        err_o;
  logic [7:0]  byte_r [8];
  logic        err_out_r;
  logic        out_valid_r;

  always_comb begin
    err_o = err_r[LatD];
    cp    = err_o ? '0 : quo[0][15:0];
    cv    = err_o ? '0 : quo[1][11:0];
    ct    = err_o ? '0 : quo[2][11:0];
    ckp   = err_o ? '0 : quo[3][11:0];
    ckd   = err_o ? '0 : quo[4][8:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r[0] <= {3'b000, ckp[11:7]};
      byte_r[1] <= {ckp[6:0], ckd[8]};
      byte_r[2] <= ckd[7:0];
      byte_r[3] <= cp[15:8];
      byte_r[4] <= cp[7:0];
      byte_r[5] <= cv[11:4];
      byte_r[6] <= {cv[3:0], ct[11:8]};
      byte_r[7] <= ct[7:0];
      err_out_r <= err_o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LatD];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_byte0 = byte_r[0];
  assign out_frame_byte1 = byte_r[1];
  assign out_frame_byte2 = byte_r[2];
  assign out_frame_byte3 = byte_r[3];
  assign out_frame_byte4 = byte_r[4];
  assign out_frame_byte5 = byte_r[5];
  assign out_frame_byte6 = byte_r[6];
  assign out_frame_byte7 = byte_r[7];
  assign out_range_error = err_out_r;

  // A request leaving the last stage shows up as a frame
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[LatD]) |=> out_valid)
    else $error("frame lost at output stage");

  // Held frame freezes the pipeline
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_frame_byte3)))
    else $error("stalled frame changed");

  // Error frames carry zero bytes
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_frame_byte0 == 8'd0 &&
     out_frame_byte4 == 8'd0 && out_frame_byte7 == 8'd0))
    else $error("error frame has nonzero bytes");

endmodule
